// File: design/clts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clts_pkg
// Shared codes, constants and controller/datapath interface types for the
// credit link transmit scheduler.
// ----------------------------------------------------------------------------
package clts_pkg;

  // input actions
  localparam logic [1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [1:0] ACT_TX_DONE = 2'd1;
  localparam logic [1:0] ACT_RX_PKT  = 2'd2;
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_START    = 2'd0;
  localparam logic [1:0] KIND_ZERO_LEN = 2'd1;
  localparam logic [1:0] KIND_DELIVER  = 2'd2;
  localparam logic [1:0] KIND_REJECT   = 2'd3;

  // register select (paddr[2])
  localparam logic REG_INITIAL_CREDIT = 1'b0;
  localparam logic REG_CHANNEL_COUNT  = 1'b1;

  localparam logic [15:0] ZL_THRESHOLD  = 16'd128;
  localparam logic [15:0] CREDIT_CAP    = 16'd255;
  localparam logic [15:0] HDR_BYTES     = 16'd4;
  localparam logic [15:0] CREDIT_MAX    = 16'hFFFF;
  localparam logic [15:0] CREDIT_RESET  = 16'd4096;
  localparam logic [4:0]  CHCOUNT_RESET = 5'd16;

  // controller to datapath
  typedef struct packed {
    logic latch;   // capture the input item
    logic decode;  // apply the action
    logic find;    // pick lowest ready channel, read its head size
    logic check;   // credit check and start packet
    logic emit;    // move one result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sched_go;
    logic out_free;
    logic nres_zero;
    logic emit_last;
  } status_t;

endpackage
`default_nettype wire

// File: design/credit_link_tx_scheduler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// credit_link_tx_scheduler_unit
// Link-end scheduler with per-channel packet queues and byte credits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one event item: enqueue,
//   transmit done or packet received. Output channel (out_valid/out_stall)
//   carries zero to two result items per event; the final one has last set.
//   An APB port writes initial_credit (addr 0, reloads peer credit) and
//   channel_count (addr 4); write only while the block is idle.
// Sequence:
//   A sequencer walks each item: capture, decode, branch, then a schedule
//   pass (channel pick with a registered size-memory read, then the
//   credit check) when the event calls for it, then moves each result in
//   turn into the output register; the next item is accepted once the
//   last result has entered the output register.
// Reset:
//   rst clears queues (counts and heads), credits to 4096 peer / 0 owed,
//   link idle. Queue storage is not cleared; no unwritten entry is read.
// Stall:
//   A stalled result holds the output register and the sequencer waits.
// ----------------------------------------------------------------------------
module credit_link_tx_scheduler_unit #(
  parameter int NUM_CHANNELS = 16,
  parameter int QUEUE_DEPTH  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  action,
  input  wire logic [3:0]  channel,
  input  wire logic [6:0]  payload_size,
  input  wire logic [7:0]  rx_transfer_count,
  input  wire logic [7:0]  rx_credit_return,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [3:0]       out_channel,
  output logic [7:0]       packet_size,
  output logic [7:0]       credit_sent,
  output logic             last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import clts_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  clts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  clts_dpath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .st                (st),
    .action            (action),
    .channel           (channel),
    .payload_size      (payload_size),
    .rx_transfer_count (rx_transfer_count),
    .rx_credit_return  (rx_credit_return),
    .cfg_we            (cfg_we),
    .cfg_sel           (paddr[2]),
    .cfg_wdata         (pwdata),
    .cfg_rdata         (prdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .kind              (kind),
    .out_channel       (out_channel),
    .packet_size       (packet_size),
    .credit_sent       (credit_sent),
    .last              (last)
  );

  // a rejection is always the only result of its item
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_REJECT |-> last)
    else $error("reject without last");

  // zero-length packet has fixed channel and size
  a_zl_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ZERO_LEN |-> out_channel == 4'd0 && packet_size == 8'd4)
    else $error("bad zero-length packet");

  // an accepted item blocks the input until it is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

endmodule
`default_nettype wire

// File: design/clts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clts_ctrl
// Sequencer: steps one item through decode, scheduling and result emission.
// ----------------------------------------------------------------------------
module clts_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire clts_pkg::status_t st,
  output clts_pkg::cmd_t        cmd
);
  import clts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_BRANCH, S_FIND, S_CHECK, S_EMIT
  } state_t;

  state_t state, state_next;

  // decode commands from the current state
  always_comb begin
    cmd.latch  = (state == S_IDLE) && in_valid && !in_stall;
    cmd.decode = (state == S_DECODE);
    cmd.find   = (state == S_FIND);
    cmd.check  = (state == S_CHECK);
    cmd.emit   = (state == S_EMIT) && st.out_free && !st.nres_zero;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid && !in_stall) state_next = S_DECODE;
      S_DECODE: state_next = S_BRANCH;
      S_BRANCH: state_next = st.sched_go ? S_FIND : S_EMIT;
      S_FIND:   state_next = S_CHECK;
      S_CHECK:  state_next = S_EMIT;
      S_EMIT: begin
        if (st.nres_zero) state_next = S_IDLE;
        else if (st.out_free && st.emit_last) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // hold state and the registered stall
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b0;
    end else begin
      state    <= state_next;
      in_stall <= (state_next != S_IDLE);
    end
  end

endmodule
`default_nettype wire

// File: design/clts_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clts_dpath
// Queues, credit counters, register file, result slots and output register.
// ----------------------------------------------------------------------------
module clts_dpath #(
  parameter int NUM_CHANNELS = 16,
  parameter int QUEUE_DEPTH  = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire clts_pkg::cmd_t    cmd,
  output clts_pkg::status_t      st,
  input  wire logic [1:0]        action,
  input  wire logic [3:0]        channel,
  input  wire logic [6:0]        payload_size,
  input  wire logic [7:0]        rx_transfer_count,
  input  wire logic [7:0]        rx_credit_return,
  input  wire logic              cfg_we,
  input  wire logic              cfg_sel,
  input  wire logic [31:0]       cfg_wdata,
  output logic [31:0]            cfg_rdata,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             kind,
  output logic [3:0]             out_channel,
  output logic [7:0]             packet_size,
  output logic [7:0]             credit_sent,
  output logic                   last
);
  import clts_pkg::*;

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int HW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam int MD = NUM_CHANNELS * QUEUE_DEPTH;
  localparam int AW = $clog2(MD);

  // latched item
  logic [1:0]  a_action;
  logic [3:0]  a_ch;
  logic [6:0]  a_pay;
  logic [7:0]  a_xc;
  logic [7:0]  a_cr;

  // link state
  logic [NW-1:0] counts [NUM_CHANNELS];
  logic [HW-1:0] heads  [NUM_CHANNELS];
  logic [7:0]    mem    [MD];
  logic [7:0]    rd_data;
  logic [15:0]   peer_credit, owed_credit, init_credit;
  logic [4:0]    active_chans;
  logic          idle_flag;
  logic [CW-1:0] inflight;
  logic [CW-1:0] sel_ch;
  logic          found, sched_go;

  // result slots
  logic [1:0] res_kind [2];
  logic [3:0] res_ch   [2];
  logic [7:0] res_size [2];
  logic [7:0] res_cred [2];
  logic [1:0] nres;
  logic       eidx;

  // ---- combinational helpers ----
  logic [CW-1:0] a_idx, q_idx;
  logic [NW-1:0] q_count;
  logic [HW-1:0] q_head;
  logic          in_range, enq_ok;
  logic [NW:0]   pos_sum;
  logic [HW-1:0] pos;
  logic [AW-1:0] waddr, raddr;
  logic [8:0]    rx_size;
  logic [16:0]   peer_add, owed_add;
  logic [15:0]   owed_sat;
  logic [15:0]   take;
  logic [NUM_CHANNELS-1:0] nz;
  logic [CW-1:0] pe_ch;
  logic          pe_any;
  logic [HW:0]   head_inc;

  assign a_idx   = CW'(a_ch);
  assign q_idx   = (a_action == ACT_TX_DONE) ? inflight : a_idx;
  assign q_count = counts[q_idx];
  assign q_head  = heads[q_idx];

  assign in_range = ({1'b0, a_ch} < active_chans) && (32'(a_ch) < NUM_CHANNELS);
  assign enq_ok   = in_range && (a_pay[1:0] == 2'b00) && (q_count < NW'(QUEUE_DEPTH));

  assign pos_sum = (NW+1)'(q_head) + (NW+1)'(q_count);
  assign pos     = (pos_sum >= (NW+1)'(QUEUE_DEPTH)) ?
                   HW'(pos_sum - (NW+1)'(QUEUE_DEPTH)) : HW'(pos_sum);
  assign waddr   = AW'(a_idx) * AW'(QUEUE_DEPTH) + AW'(pos);
  assign head_inc = (HW+1)'(q_head) + (HW+1)'(1);

  assign rx_size  = ((9'(a_xc) + 9'd1) >> 1) + 9'd2;
  assign peer_add = 17'(peer_credit) + 17'(a_cr);
  assign owed_add = 17'(owed_credit) + 17'(rx_size);
  assign owed_sat = owed_add[16] ? CREDIT_MAX : owed_add[15:0];

  assign take = (owed_credit > CREDIT_CAP) ? CREDIT_CAP : owed_credit;

  // lowest channel with a queued packet
  always_comb begin
    pe_any = 1'b0;
    pe_ch  = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      nz[i] = (counts[i] != '0);
      if (nz[i] && !pe_any) begin
        pe_any = 1'b1;
        pe_ch  = CW'(i);
      end
    end
  end
  assign raddr = AW'(pe_ch) * AW'(QUEUE_DEPTH) + AW'(heads[pe_ch]);

  // ---- status ----
  always_comb begin
    st.sched_go  = sched_go;
    st.out_free  = !out_valid || !out_stall;
    st.nres_zero = (nres == 2'd0);
    st.emit_last = eidx || (nres == 2'd1);
  end

  assign cfg_rdata = (cfg_sel == REG_CHANNEL_COUNT) ? 32'(active_chans) : 32'(init_credit);

  // capture the item
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      a_action <= action;
      a_ch     <= channel;
      a_pay    <= payload_size;
      a_xc     <= rx_transfer_count;
      a_cr     <= rx_credit_return;
    end
  end

  // size memory: write on enqueue, registered read on find
  always_ff @(posedge clk) begin
    if (cmd.decode && a_action == ACT_ENQUEUE && enq_ok)
      mem[waddr] <= {1'b0, a_pay} + 8'(HDR_BYTES);
  end
  always_ff @(posedge clk) begin
    if (cmd.find) rd_data <= mem[raddr];
  end

  // link state, config and result slots
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        counts[i] <= '0;
        heads[i]  <= '0;
      end
      peer_credit  <= CREDIT_RESET;
      owed_credit  <= '0;
      init_credit  <= CREDIT_RESET;
      active_chans <= CHCOUNT_RESET;
      idle_flag    <= 1'b1;
      inflight     <= '0;
      sched_go     <= 1'b0;
      found        <= 1'b0;
      nres         <= '0;
      eidx         <= 1'b0;
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_sel == REG_INITIAL_CREDIT) begin
          init_credit <= cfg_wdata[15:0];
          peer_credit <= cfg_wdata[15:0];
        end else begin
          active_chans <= cfg_wdata[4:0];
        end
      end

      // apply the action
      if (cmd.decode) begin
        nres     <= '0;
        eidx     <= 1'b0;
        sched_go <= 1'b0;
        case (a_action)
          ACT_ENQUEUE: begin
            if (enq_ok) begin
              counts[a_idx] <= q_count + NW'(1);
              sched_go      <= idle_flag;
            end else begin
              res_kind[0] <= KIND_REJECT;
              res_ch[0]   <= a_ch;
              res_size[0] <= '0;
              res_cred[0] <= '0;
              nres        <= 2'd1;
            end
          end
          ACT_TX_DONE: begin
            if (!idle_flag) begin
              if (q_count != '0) begin
                heads[q_idx]  <= (head_inc >= (HW+1)'(QUEUE_DEPTH)) ? '0 : HW'(head_inc);
                counts[q_idx] <= q_count - NW'(1);
              end
              sched_go <= 1'b1;
            end
          end
          ACT_RX_PKT: begin
            peer_credit <= peer_add[16] ? CREDIT_MAX : peer_add[15:0];
            owed_credit <= owed_sat;
            if (rx_size > 9'd4) begin
              res_kind[0] <= KIND_DELIVER;
              res_ch[0]   <= a_ch;
              res_size[0] <= 8'(rx_size - 9'd4);
              res_cred[0] <= '0;
              nres        <= 2'd1;
            end
            sched_go <= idle_flag && ((a_cr != 8'd0) || (owed_sat > ZL_THRESHOLD));
          end
          default: ;
        endcase
      end

      // pick channel; none queued: zero-length packet if credit allows
      if (cmd.find) begin
        found  <= pe_any;
        sel_ch <= pe_ch;
        if (!pe_any) begin
          idle_flag <= 1'b1;
          if (owed_credit > ZL_THRESHOLD && peer_credit >= HDR_BYTES) begin
            owed_credit          <= owed_credit - take;
            peer_credit          <= peer_credit - HDR_BYTES;
            res_kind[nres[0]]    <= KIND_ZERO_LEN;
            res_ch[nres[0]]      <= '0;
            res_size[nres[0]]    <= 8'(HDR_BYTES);
            res_cred[nres[0]]    <= 8'(take);
            nres                 <= nres + 2'd1;
          end
        end
      end

      // credit check and start
      if (cmd.check && found) begin
        if (16'(rd_data) > peer_credit) begin
          idle_flag <= 1'b1;
        end else begin
          idle_flag            <= 1'b0;
          inflight             <= sel_ch;
          peer_credit          <= peer_credit - 16'(rd_data);
          owed_credit          <= owed_credit - take;
          res_kind[nres[0]]    <= KIND_START;
          res_ch[nres[0]]      <= 4'(sel_ch);
          res_size[nres[0]]    <= rd_data;
          res_cred[nres[0]]    <= 8'(take);
          nres                 <= nres + 2'd1;
        end
      end

      if (cmd.emit) eidx <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind        <= res_kind[eidx];
      out_channel <= res_ch[eidx];
      packet_size <= res_size[eidx];
      credit_sent <= res_cred[eidx];
      last        <= st.emit_last;
    end
  end

endmodule
`default_nettype wire
